// ===== rtl/core/pngu_pkg.sv =====
// Package for the PNG scanline unfilter core.
// Holds field widths, register indexes, filter codes and the word types of the two streams.
// No dependencies.
package pngu_pkg;

  // Parameter defaults
  localparam int MAX_LINE_BYTES_DEF  = 16384;
  localparam int MAX_PIXEL_BYTES_DEF = 8;

  // Register and field widths
  localparam int BPP_W   = 4;
  localparam int LEN_W   = 15;
  localparam int CFG_W   = 15;
  localparam int INDEX_W = 1;

  // Register indexes
  localparam logic [INDEX_W-1:0] REG_BYTES_PER_PIXEL = 1'd0;
  localparam logic [INDEX_W-1:0] REG_LINE_BYTES      = 1'd1;

  // Register reset values
  localparam logic [BPP_W-1:0] BPP_RESET = 4'd3;
  localparam logic [LEN_W-1:0] LEN_RESET = 15'd3;

  // Filter type codes
  localparam logic [7:0] FILT_NONE  = 8'd0;
  localparam logic [7:0] FILT_SUB   = 8'd1;
  localparam logic [7:0] FILT_UP    = 8'd2;
  localparam logic [7:0] FILT_AVG   = 8'd3;
  localparam logic [7:0] FILT_PAETH = 8'd4;

  // Byte given for a line with an unknown filter type
  localparam logic [7:0] BAD_FILL = 8'hFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       image_start;
  } in_word_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       line_end;
    logic       bad_filter;
  } out_word_t;

endpackage

// ===== rtl/core/pngu_stream_if.sv =====
// Valid/ready stream interface used by the PNG unfilter core.
// The word type is a parameter; the core uses the word types of pngu_pkg.
interface pngu_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/png_scanline_unfilter_core.sv =====
// PNG scanline unfilter core: rebuilds filtered scanline bytes in stream order.
// Pixel bytes pass the input stage register and then the output register.
// Throughput: 1 byte per cycle unless the output stalls; the line buffer read
// is issued as the byte is taken. Filter type bytes give no output word. Synchronous
// active-high reset sets bytes_per_pixel and line_bytes to 3 and expects a filter
// byte of a first line. Depends on pngu_pkg, pngu_stream_if, pngu_ram and pngu_recon.
module png_scanline_unfilter_core #(
  parameter int MAX_LINE_BYTES  = pngu_pkg::MAX_LINE_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = pngu_pkg::MAX_PIXEL_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [pngu_pkg::INDEX_W-1:0]  wr_index,
  input  logic [pngu_pkg::CFG_W-1:0]    wr_data,
  pngu_stream_if.sink                   byte_stream,
  pngu_stream_if.source                 pixel_stream
);
  import pngu_pkg::*;

  localparam int PW = $clog2(MAX_LINE_BYTES + 1);
  localparam int AW = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
  localparam int HW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int CW = (PW > LEN_W) ? PW : LEN_W;

  // Configuration registers
  logic [BPP_W-1:0] bytes_per_pixel;
  logic [LEN_W-1:0] line_bytes;

  // Line state
  logic [PW-1:0] line_position;
  logic [PW-1:0] line_position_next;
  logic          first_line;
  logic          first_line_next;
  logic [7:0]    line_filter;
  logic [7:0]    line_filter_next;
  logic [7:0]    left_hist [MAX_PIXEL_BYTES];
  logic [7:0]    left_hist_next [MAX_PIXEL_BYTES];
  logic [7:0]    up_left_hist [MAX_PIXEL_BYTES];
  logic [7:0]    up_left_hist_next [MAX_PIXEL_BYTES];

  // Input stage and output register
  logic      stage_valid;
  in_word_t  stage_word;
  logic      out_valid;
  out_word_t out_word;

  // Effective register values
  logic [PW-1:0]    eff_len;
  logic [BPP_W-1:0] eff_bpp;
  logic [HW-1:0]    hist_idx;

  // Working signals of the stage
  logic          accept;
  logic          advance;
  logic          start;
  logic [PW-1:0] cur_position;
  logic          cur_first;
  logic          is_pixel;
  logic [PW-1:0] pos;
  logic [PW-1:0] pos_inc;
  logic          has_left;
  logic          last;
  logic [7:0]    a_byte;
  logic [7:0]    b_byte;
  logic [7:0]    c_byte;
  logic [7:0]    val;
  logic          bad;
  logic [7:0]    prior_byte;

  // Line buffer read address for the word being taken
  logic [PW-1:0] pred_position;
  logic [PW-1:0] pred_pos;
  logic [AW-1:0] rd_addr;

  // Clamp the registers to their legal ranges
  always_comb begin
    if (line_bytes == '0) begin
      eff_len = PW'(1);
    end else if (CW'(line_bytes) > CW'(MAX_LINE_BYTES)) begin
      eff_len = PW'(MAX_LINE_BYTES);
    end else begin
      eff_len = PW'(line_bytes);
    end
    if (bytes_per_pixel == '0) begin
      eff_bpp = BPP_W'(1);
    end else if (32'(bytes_per_pixel) > 32'(MAX_PIXEL_BYTES)) begin
      eff_bpp = BPP_W'(MAX_PIXEL_BYTES);
    end else begin
      eff_bpp = bytes_per_pixel;
    end
    hist_idx = HW'(eff_bpp - BPP_W'(1));
  end

  // Handshake: a filter byte always moves on, a pixel byte needs room at the output
  assign is_pixel         = stage_valid && (cur_position != '0);
  assign advance          = stage_valid && (!is_pixel || !out_valid || pixel_stream.ready);
  assign byte_stream.ready = !stage_valid || advance;
  assign accept           = byte_stream.valid && byte_stream.ready;

  // Position and neighbors of the byte in the stage
  always_comb begin
    start        = stage_word.image_start;
    cur_position = start ? '0 : line_position;
    cur_first    = start || first_line;
    pos          = ((cur_position - PW'(1)) >= eff_len) ? eff_len - PW'(1)
                                                        : cur_position - PW'(1);
    pos_inc      = pos + PW'(1);
    last         = pos_inc >= eff_len;
    has_left     = CW'(pos) >= CW'(eff_bpp);
    a_byte       = (has_left && !start) ? left_hist[hist_idx] : 8'd0;
    b_byte       = cur_first ? 8'd0 : prior_byte;
    c_byte       = (has_left && !cur_first) ? up_left_hist[hist_idx] : 8'd0;
  end

  pngu_recon u_recon (
    .filter_type  (line_filter),
    .data_byte    (stage_word.data_byte),
    .left_byte    (a_byte),
    .up_byte      (b_byte),
    .up_left_byte (c_byte),
    .pixel_byte   (val),
    .bad_filter   (bad)
  );

  // Next line state after the byte in the stage
  always_comb begin
    line_position_next = line_position;
    first_line_next    = first_line;
    line_filter_next   = line_filter;
    for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
      left_hist_next[k]    = start ? 8'd0 : left_hist[k];
      up_left_hist_next[k] = start ? 8'd0 : up_left_hist[k];
    end
    if (stage_valid) begin
      first_line_next = cur_first;
      if (cur_position == '0) begin
        line_filter_next   = stage_word.data_byte;
        line_position_next = PW'(1);
      end else if (last) begin
        line_position_next = '0;
        first_line_next    = 1'b0;
        for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
          left_hist_next[k]    = 8'd0;
          up_left_hist_next[k] = 8'd0;
        end
      end else begin
        line_position_next = pos + PW'(2);
        for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
          left_hist_next[k]    = left_hist[k-1];
          up_left_hist_next[k] = up_left_hist[k-1];
        end
        left_hist_next[0]    = val;
        up_left_hist_next[0] = b_byte;
      end
    end
  end

  // Predict the position of the word being taken and address the line buffer
  always_comb begin
    pred_position = stage_valid ? line_position_next : line_position;
    pred_pos      = ((pred_position - PW'(1)) >= eff_len) ? eff_len - PW'(1)
                                                          : pred_position - PW'(1);
    rd_addr       = pred_pos[AW-1:0];
  end

  pngu_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LINE_BYTES)
  ) u_prior_line (
    .clk     (clk),
    .wr_en   (advance && is_pixel),
    .wr_addr (pos[AW-1:0]),
    .wr_data (val),
    .rd_en   (accept && !byte_stream.payload.image_start),
    .rd_addr (rd_addr),
    .rd_data (prior_byte)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= BPP_RESET;
      line_bytes      <= LEN_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_BYTES_PER_PIXEL: bytes_per_pixel <= wr_data[BPP_W-1:0];
        REG_LINE_BYTES:      line_bytes      <= wr_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Commit line state when the stage moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      line_position <= '0;
      first_line    <= 1'b1;
      line_filter   <= 8'd0;
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        left_hist[k]    <= 8'd0;
        up_left_hist[k] <= 8'd0;
      end
    end else if (advance) begin
      line_position <= line_position_next;
      first_line    <= first_line_next;
      line_filter   <= line_filter_next;
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        left_hist[k]    <= left_hist_next[k];
        up_left_hist[k] <= up_left_hist_next[k];
      end
    end
  end

  // Input stage: take a word, hold it while the output is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (byte_stream.ready) begin
      stage_valid <= byte_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_word <= byte_stream.payload;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && is_pixel) begin
      out_valid <= 1'b1;
    end else if (pixel_stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_pixel) begin
      out_word.pixel_byte <= val;
      out_word.line_end   <= last;
      out_word.bad_filter <= bad;
    end
  end

  assign pixel_stream.valid   = out_valid;
  assign pixel_stream.payload = out_word;

endmodule

// ===== rtl/core/pngu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the previous-row line buffer.
module pngu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/pngu_recon.sv =====
// Byte reconstruction for one filtered PNG byte: None, Sub, Up, Average, Paeth.
// Depends on pngu_pkg for the filter codes and the fill byte.
module pngu_recon (
  input  logic [7:0] filter_type,
  input  logic [7:0] data_byte,
  input  logic [7:0] left_byte,
  input  logic [7:0] up_byte,
  input  logic [7:0] up_left_byte,
  output logic [7:0] pixel_byte,
  output logic       bad_filter
);
  import pngu_pkg::*;

  logic [8:0]        avg_sum;
  logic signed [9:0] dist_a;
  logic signed [9:0] dist_b;
  logic signed [9:0] dist_c;
  logic [9:0]        pa;
  logic [9:0]        pb;
  logic [9:0]        pc;
  logic [7:0]        pred;

  // Paeth distances: pa = |b - c|, pb = |a - c|, pc = |a + b - 2c|
  always_comb begin
    dist_a = $signed({2'b00, up_byte}) - $signed({2'b00, up_left_byte});
    dist_b = $signed({2'b00, left_byte}) - $signed({2'b00, up_left_byte});
    dist_c = dist_a + dist_b;
    pa = (dist_a < 0) ? 10'(-dist_a) : 10'(dist_a);
    pb = (dist_b < 0) ? 10'(-dist_b) : 10'(dist_b);
    pc = (dist_c < 0) ? 10'(-dist_c) : 10'(dist_c);
    if (pa <= pb && pa <= pc) begin
      pred = left_byte;
    end else if (pb <= pc) begin
      pred = up_byte;
    end else begin
      pred = up_left_byte;
    end
  end

  // Apply the line's filter rule or BAD_FILL; adds to data_byte wrap at 8 bits
  always_comb begin
    avg_sum    = {1'b0, left_byte} + {1'b0, up_byte};
    bad_filter = 1'b0;
    case (filter_type)
      FILT_NONE:  pixel_byte = data_byte;
      FILT_SUB:   pixel_byte = data_byte + left_byte;
      FILT_UP:    pixel_byte = data_byte + up_byte;
      FILT_AVG:   pixel_byte = data_byte + avg_sum[8:1];
      FILT_PAETH: pixel_byte = data_byte + pred;
      default: begin
        pixel_byte = BAD_FILL;
        bad_filter = 1'b1;
      end
    endcase
  end

endmodule
